@@ design/rx256_pkg.sv @@
// rx256_pkg: types, constants and helper functions shared by the xterm-256 quantizer.
// Standalone package; used by rx256_cube_path, rx256_grey_path and rgb_to_xterm256_index.
package rx256_pkg;

  typedef logic [7:0] chan_t;
  typedef logic [2:0] lvl_idx_t;
  typedef logic [4:0] grey_step_t;
  typedef logic [13:0] cube_dist_t;
  typedef logic [17:0] grey_dist_t;

  localparam logic [7:0] CUBE_BASE     = 8'd16;
  localparam logic [7:0] GREY_BASE     = 8'd232;
  localparam grey_step_t GREY_MAX_STEP = 5'd23;
  localparam logic [7:0] GREY_OFFSET   = 8'd8;
  // 1/3 and 1/10 as fixed-point reciprocals, both exact over the value ranges used
  localparam logic [9:0] RECIP3        = 10'd683;  // 683 / 2^11
  localparam logic [7:0] RECIP10       = 8'd205;   // 205 / 2^11

  // Nearest cube level; the midpoint between 95 and 135 (and others) goes low.
  function automatic lvl_idx_t nearest_level(input chan_t v);
    lvl_idx_t idx;
    if (v < 8'd48)       idx = 3'd0;
    else if (v < 8'd116) idx = 3'd1;
    else if (v < 8'd156) idx = 3'd2;
    else if (v < 8'd196) idx = 3'd3;
    else if (v < 8'd236) idx = 3'd4;
    else                 idx = 3'd5;
    return idx;
  endfunction

  function automatic chan_t cube_level(input lvl_idx_t idx);
    chan_t lvl;
    unique case (idx)
      3'd0:    lvl = 8'd0;
      3'd1:    lvl = 8'd95;
      3'd2:    lvl = 8'd135;
      3'd3:    lvl = 8'd175;
      3'd4:    lvl = 8'd215;
      default: lvl = 8'd255;
    endcase
    return lvl;
  endfunction

  function automatic chan_t abs_diff(input chan_t a, input chan_t b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

@@ design/rx256_cube_path.sv @@
// rx256_cube_path: color-cube candidate (index and squared distance), five register stages.
// Depends on rx256_pkg.
module rx256_cube_path (
  input  logic                clk,
  input  rx256_pkg::chan_t    red,
  input  rx256_pkg::chan_t    green,
  input  rx256_pkg::chan_t    blue,
  output logic [7:0]          cube_entry,
  output rx256_pkg::cube_dist_t cube_dist
);

  // stage 1: level indices
  rx256_pkg::chan_t    red1_r, green1_r, blue1_r;
  rx256_pkg::lvl_idx_t ri1_r, gi1_r, bi1_r;
  // stage 2: per-channel distance to level, cube index
  logic [5:0]          dr2_r, dg2_r, db2_r;
  logic [7:0]          idx2_r, idx3_r, idx4_r, idx5_r;
  rx256_pkg::chan_t    dr2_nxt, dg2_nxt, db2_nxt;
  logic [7:0]          idx2_nxt;
  // stage 3..5: squared distance
  rx256_pkg::cube_dist_t dist3_nxt, dist3_r, dist4_r, dist5_r;
  logic [11:0]         sq_r, sq_g, sq_b;

  always_comb begin
    dr2_nxt  = rx256_pkg::abs_diff(red1_r, rx256_pkg::cube_level(ri1_r));
    dg2_nxt  = rx256_pkg::abs_diff(green1_r, rx256_pkg::cube_level(gi1_r));
    db2_nxt  = rx256_pkg::abs_diff(blue1_r, rx256_pkg::cube_level(bi1_r));
    // 36*ri + 6*gi + bi, with shifts
    idx2_nxt = rx256_pkg::CUBE_BASE + {ri1_r, 5'd0} + {3'd0, ri1_r, 2'd0}
             + {4'd0, gi1_r, 1'b0} + {3'd0, gi1_r, 2'd0} + {5'd0, bi1_r};
  end

  always_comb begin
    sq_r      = 12'(dr2_r) * 12'(dr2_r);
    sq_g      = 12'(dg2_r) * 12'(dg2_r);
    sq_b      = 12'(db2_r) * 12'(db2_r);
    dist3_nxt = 14'(sq_r) + 14'(sq_g) + 14'(sq_b);
  end

  always_ff @(posedge clk) begin
    red1_r   <= red;
    green1_r <= green;
    blue1_r  <= blue;
    ri1_r    <= rx256_pkg::nearest_level(red);
    gi1_r    <= rx256_pkg::nearest_level(green);
    bi1_r    <= rx256_pkg::nearest_level(blue);
    // half gap is at most 47, so six bits hold the distance
    dr2_r    <= dr2_nxt[5:0];
    dg2_r    <= dg2_nxt[5:0];
    db2_r    <= db2_nxt[5:0];
    idx2_r   <= idx2_nxt;
    dist3_r  <= dist3_nxt;
    idx3_r   <= idx2_r;
    dist4_r  <= dist3_r;
    idx4_r   <= idx3_r;
    dist5_r  <= dist4_r;
    idx5_r   <= idx4_r;
  end

  assign cube_entry = idx5_r;
  assign cube_dist  = dist5_r;

endmodule

@@ design/rx256_grey_path.sv @@
// rx256_grey_path: grey-ramp candidate (step and squared distance), five register stages.
// Depends on rx256_pkg.
module rx256_grey_path (
  input  logic                  clk,
  input  rx256_pkg::chan_t      red,
  input  rx256_pkg::chan_t      green,
  input  rx256_pkg::chan_t      blue,
  output rx256_pkg::grey_step_t grey_step,
  output rx256_pkg::grey_dist_t grey_dist
);

  rx256_pkg::chan_t      red1_r, green1_r, blue1_r;
  rx256_pkg::chan_t      red2_r, green2_r, blue2_r;
  rx256_pkg::chan_t      red3_r, green3_r, blue3_r;
  logic [9:0]            sum1_r;
  logic [19:0]           mean_prod;
  rx256_pkg::chan_t      mean2_r;
  rx256_pkg::chan_t      mean_ofs;
  logic [15:0]           step_prod;
  rx256_pkg::grey_step_t step_raw, step3_nxt, step3_r, step4_r, step5_r;
  rx256_pkg::chan_t      grey_lvl;
  rx256_pkg::chan_t      dr4_r, dg4_r, db4_r;
  logic [15:0]           sq_r, sq_g, sq_b;
  rx256_pkg::grey_dist_t dist5_nxt, dist5_r;

  // mean = sum / 3 by reciprocal multiply
  assign mean_prod = 20'(sum1_r) * 20'(rx256_pkg::RECIP3);

  // step = (mean - 8) / 10, zero for a dark mean, clamped at the top of the ramp
  always_comb begin
    mean_ofs  = mean2_r - rx256_pkg::GREY_OFFSET;
    step_prod = 16'(mean_ofs) * 16'(rx256_pkg::RECIP10);
    step_raw  = step_prod[15:11];
    if (mean2_r < rx256_pkg::GREY_OFFSET)          step3_nxt = '0;
    else if (step_raw > rx256_pkg::GREY_MAX_STEP)  step3_nxt = rx256_pkg::GREY_MAX_STEP;
    else                                           step3_nxt = step_raw;
  end

  // grey level 8 + 10*step
  assign grey_lvl = rx256_pkg::GREY_OFFSET + {step3_r, 3'd0} + {2'd0, step3_r, 1'b0};

  always_comb begin
    sq_r      = 16'(dr4_r) * 16'(dr4_r);
    sq_g      = 16'(dg4_r) * 16'(dg4_r);
    sq_b      = 16'(db4_r) * 16'(db4_r);
    dist5_nxt = 18'(sq_r) + 18'(sq_g) + 18'(sq_b);
  end

  always_ff @(posedge clk) begin
    red1_r   <= red;
    green1_r <= green;
    blue1_r  <= blue;
    sum1_r   <= 10'(red) + 10'(green) + 10'(blue);
    red2_r   <= red1_r;
    green2_r <= green1_r;
    blue2_r  <= blue1_r;
    mean2_r  <= mean_prod[18:11];
    red3_r   <= red2_r;
    green3_r <= green2_r;
    blue3_r  <= blue2_r;
    step3_r  <= step3_nxt;
    dr4_r    <= rx256_pkg::abs_diff(red3_r, grey_lvl);
    dg4_r    <= rx256_pkg::abs_diff(green3_r, grey_lvl);
    db4_r    <= rx256_pkg::abs_diff(blue3_r, grey_lvl);
    step4_r  <= step3_r;
    dist5_r  <= dist5_nxt;
    step5_r  <= step4_r;
  end

  assign grey_step = step5_r;
  assign grey_dist = dist5_r;

endmodule

@@ design/rgb_to_xterm256_index.sv @@
// rgb_to_xterm256_index: nearest xterm-256 palette entry for a 24-bit RGB pixel.
// Depends on rx256_pkg, rx256_cube_path, rx256_grey_path.
//
//   channel  | ports                              | handshake
//   ---------+------------------------------------+--------------------------------
//   input    | in_red, in_green, in_blue          | start && !busy
//   result   | out_palette_index                  | out_valid, one-cycle strobe
//
// One pixel per cycle; busy stays low. An accepted transaction passes the input
// register, five stages in the cube and grey paths (the square-and-sum is the deepest
// step), and the output register to the result ports. Synchronous reset clears the
// valid pipeline only. The receiver cannot stall, so nothing is ever held back.
module rgb_to_xterm256_index (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  output logic       out_valid,
  output logic [7:0] out_palette_index
);

  logic                  accept;
  rx256_pkg::chan_t      red_r, green_r, blue_r;
  logic [5:0]            vld_r, vld_nxt;
  logic [7:0]            cube_entry;
  rx256_pkg::cube_dist_t cube_dist;
  rx256_pkg::grey_step_t grey_step;
  rx256_pkg::grey_dist_t grey_dist;
  logic                  grey_wins;
  logic [7:0]            index_nxt;
  logic                  out_valid_r;
  logic [7:0]            out_palette_index_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (accept) begin
      red_r   <= in_red;
      green_r <= in_green;
      blue_r  <= in_blue;
    end
  end

  rx256_cube_path u_cube (
    .clk        (clk),
    .red        (red_r),
    .green      (green_r),
    .blue       (blue_r),
    .cube_entry (cube_entry),
    .cube_dist  (cube_dist)
  );

  rx256_grey_path u_grey (
    .clk       (clk),
    .red       (red_r),
    .green     (green_r),
    .blue      (blue_r),
    .grey_step (grey_step),
    .grey_dist (grey_dist)
  );

  // grey only when strictly closer
  always_comb begin
    grey_wins = grey_dist < 18'(cube_dist);
    index_nxt = grey_wins ? (rx256_pkg::GREY_BASE + 8'(grey_step)) : cube_entry;
    vld_nxt   = {vld_r[4:0], accept};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= vld_nxt;
      out_valid_r <= vld_r[5];
    end
  end

  always_ff @(posedge clk) begin
    out_palette_index_r <= index_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_palette_index = out_palette_index_r;

  // every result traces back to an accepted transaction
  a_no_phantom: assert property (@(posedge clk)
    out_valid |-> $past(start && !busy, 7))
    else $error("result without matching accepted transaction");

  // every accepted transaction out of reset yields a result
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $past(start && !busy, 7) && $past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3)
      && $past(rst_n, 4) && $past(rst_n, 5) && $past(rst_n, 6) && $past(rst_n, 7)
      |-> out_valid)
    else $error("accepted transaction produced no result");

  // palette index never falls in the 16 system colors
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_palette_index >= rx256_pkg::CUBE_BASE)
    else $error("palette index below cube base");

endmodule
